@@ sv/dbr_pkg.sv @@
// ----------------------------------------------------------------------------
// dbr_pkg
// shared types, constants and helpers for the discrete b-spline row block
// ----------------------------------------------------------------------------
package dbr_pkg;

    localparam int DEF_MAX_ORDER  = 8;
    localparam int DEF_KNOT_DEPTH = 1024;

    localparam int KNOT_W = 32;
    localparam int DIFF_W = 33;
    localparam int DIV_W  = 34;
    localparam int PROD_W = 64;
    localparam int QUO_W  = 31;
    localparam int DIV_CW = 5;

    localparam logic [1:0] OP_LOAD_ORIG = 2'd0;
    localparam logic [1:0] OP_LOAD_REF  = 2'd1;
    localparam logic [1:0] OP_ROW       = 2'd2;

    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_DIM   = 1'b1;

    localparam logic [3:0] ORDER_RESET = 4'd4;
    localparam logic [9:0] DIM_RESET   = 10'd16;

    localparam logic signed [KNOT_W-1:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [KNOT_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KNOT_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_COLL_RD,
        ST_COLL_CMP,
        ST_BUILD_INIT,
        ST_BUILD_T0,
        ST_KNOT_TOP,
        ST_TB_CAP,
        ST_TB_WAIT,
        ST_INNER_TOP,
        ST_INNER_RD2,
        ST_INNER_CAP,
        ST_T2_START,
        ST_T2_WAIT,
        ST_T1_START,
        ST_T1_WAIT,
        ST_TAIL_RD2,
        ST_TAIL_CAP,
        ST_TAIL_START,
        ST_TAIL_WAIT,
        ST_EMIT_INIT,
        ST_EMIT
    } dbr_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL_LO,
        SC_MUL_HI,
        SC_ADD,
        SC_CHK,
        SC_DIV,
        SC_FIN
    } sc_state_t;

    typedef struct packed {
        logic                       start;
        logic signed [DIFF_W-1:0]   a;
        logic signed [KNOT_W-1:0]   e;
        logic signed [DIV_W-1:0]    d;
    } sc_req_t;

    typedef struct packed {
        logic                       done;
        logic                       zero;
        logic signed [KNOT_W-1:0]   q;
    } sc_rsp_t;

    function automatic logic signed [KNOT_W-1:0] sat_add(
        input logic signed [KNOT_W-1:0] x,
        input logic signed [KNOT_W-1:0] y
    );
        logic signed [KNOT_W:0] s;
        s = (KNOT_W+1)'(x) + (KNOT_W+1)'(y);
        if (s[KNOT_W] != s[KNOT_W-1]) begin
            return s[KNOT_W] ? SAT_MIN : SAT_MAX;
        end
        return s[KNOT_W-1:0];
    endfunction

endpackage

@@ sv/dbr_scale.sv @@
// ----------------------------------------------------------------------------
// dbr_scale
// shared scaler: a*e/d rounded half away from zero, saturated to 32 bits,
// a split multiply of low and high partial products and a 31-step restoring divider
// ----------------------------------------------------------------------------
module dbr_scale
    import dbr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  sc_req_t req,
    output sc_rsp_t rsp
);

    sc_state_t state_reg, state_next;

    logic [DIFF_W-1:0] am_reg, am_next;
    logic [KNOT_W-1:0] em_reg, em_next;
    logic [DIV_W-1:0]  md_reg, md_next;
    logic              neg_reg, neg_next;
    logic              dz_reg, dz_next;
    logic              sat_reg, sat_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;

    logic [48:0] p_lo;
    logic [47:0] p_hi;
    logic        ge;
    logic        prod_neg;

    assign p_lo = am_reg[16:0] * em_reg;
    assign p_hi = am_reg[32:17] * em_reg;
    assign ge   = acc_reg >= dsh_reg;
    assign prod_neg = (req.a[DIFF_W-1] ^ req.e[KNOT_W-1]) && (req.a != '0) && (req.e != '0);

    always_comb begin : next_state
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE:   if (req.start) state_next = (req.d == '0) ? SC_FIN : SC_MUL_LO;
            SC_MUL_LO: state_next = SC_MUL_HI;
            SC_MUL_HI: state_next = SC_ADD;
            SC_ADD:    state_next = SC_CHK;
            SC_CHK:    state_next = ({1'b0, acc_reg} >= {md_reg, 31'b0}) ? SC_FIN : SC_DIV;
            SC_DIV:    if (cnt_reg == '0) state_next = SC_FIN;
            SC_FIN:    state_next = SC_IDLE;
            default:   state_next = SC_IDLE;
        endcase
    end

    always_comb begin : datapath
        am_next  = am_reg;
        em_next  = em_reg;
        md_next  = md_reg;
        neg_next = neg_reg;
        dz_next  = dz_reg;
        sat_next = sat_reg;
        acc_next = acc_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        rsp      = '0;
        unique case (state_reg)
            SC_IDLE: begin
                if (req.start) begin
                    am_next  = req.a[DIFF_W-1] ? DIFF_W'(-req.a) : DIFF_W'(req.a);
                    em_next  = req.e[KNOT_W-1] ? KNOT_W'(-req.e) : KNOT_W'(req.e);
                    md_next  = req.d[DIV_W-1] ? DIV_W'(-req.d) : DIV_W'(req.d);
                    neg_next = prod_neg ^ req.d[DIV_W-1];
                    dz_next  = (req.d == '0);
                    sat_next = 1'b0;
                    q_next   = '0;
                end
            end
            SC_MUL_LO: acc_next = PROD_W'(p_lo);
            SC_MUL_HI: acc_next = acc_reg + PROD_W'({p_hi, 17'b0});
            SC_ADD:    acc_next = acc_reg + PROD_W'(md_reg >> 1);
            SC_CHK: begin
                sat_next = {1'b0, acc_reg} >= {md_reg, 31'b0};
                dsh_next = PROD_W'({md_reg, 30'b0});
                cnt_next = DIV_CW'(QUO_W - 1);
            end
            SC_DIV: begin
                if (ge) acc_next = acc_reg - dsh_reg;
                q_next   = {q_reg[QUO_W-2:0], ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
            end
            SC_FIN: begin
                rsp.done = 1'b1;
                rsp.zero = dz_reg;
                if (dz_reg) rsp.q = '0;
                else if (sat_reg) rsp.q = neg_reg ? SAT_MIN : SAT_MAX;
                else rsp.q = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= SC_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        am_reg  <= am_next;
        em_reg  <= em_next;
        md_reg  <= md_next;
        neg_reg <= neg_next;
        dz_reg  <= dz_next;
        sat_reg <= sat_next;
        acc_reg <= acc_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

endmodule

@@ sv/discrete_bspline_row.sv @@
// ----------------------------------------------------------------------------
// discrete_bspline_row
// one row of the b-spline knot insertion matrix by the oslo recurrence
// ----------------------------------------------------------------------------
// Load words (op 0, op 1) write one knot; busy stays low.
// A row word (op 2) raises busy until its last result has been issued. The
// row walks down past shared knots and collects the new knots, then runs
// the inner steps and order tails on the shared scaler, started once per
// product-quotient term, whose 31-step restoring divider is skipped on a zero
// divisor or an overflowing quotient. Results then leave one per cycle,
// each strobed by result_valid for exactly one cycle, and the receiver cannot
// stall them. Knot stores hold no reset contents: read only written entries.
// ----------------------------------------------------------------------------
module discrete_bspline_row
    import dbr_pkg::*;
#(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int KNOT_DEPTH = DEF_KNOT_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [9:0]         knot_index,
    input  logic signed [31:0] knot_value,
    input  logic [9:0]         row,
    input  logic [9:0]         interval,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [9:0]         cfg_data,
    output logic               result_valid,
    output logic [30:0]        value,
    output logic [9:0]         spline_index,
    output logic [9:0]         last_position,
    output logic [2:0]         count_minus_one,
    output logic               status,
    output logic               last
);

    localparam int KIW = $clog2(KNOT_DEPTH);
    localparam int AW  = (KIW > 10) ? KIW : 10;
    localparam int SW  = AW + 3;
    localparam int CW  = ($clog2(MAX_ORDER + 1) > 3) ? $clog2(MAX_ORDER + 1) : 3;
    localparam int WIW = $clog2(MAX_ORDER);
    localparam int NKD = MAX_ORDER - 1;
    localparam int NKW = (NKD > 1) ? $clog2(NKD) : 1;

    function automatic logic signed [SW-1:0] ext(input logic [CW-1:0] v);
        return $signed(SW'({1'b0, v}));
    endfunction

    dbr_state_t state_reg, state_next;

    logic [3:0] order_reg;
    logic [9:0] dim_reg;

    logic [KNOT_W-1:0] orig_mem [KNOT_DEPTH];
    logic [KNOT_W-1:0] ref_mem  [KNOT_DEPTH];
    logic [KNOT_W-1:0] orig_q_reg, ref_q_reg;
    logic              orig_oob_reg, ref_oob_reg;
    logic signed [SW-1:0] orig_addr, ref_addr;
    logic                 orig_in, ref_in;
    logic signed [KNOT_W-1:0] okd, rkd;

    logic accept, load_in_range;
    logic [KIW-1:0] wr_addr;

    logic [CW-1:0] k_reg, k_next;
    logic [9:0]    n_reg, n_next;
    logic signed [SW-1:0] j_reg, j_next;
    logic signed [SW-1:0] jm_reg, jm_next;
    logic signed [SW-1:0] ki_reg, ki_next;
    logic signed [SW-1:0] kih_reg, kih_next;
    logic signed [SW-1:0] kiu_reg, kiu_next;
    logic [CW-1:0] kp_reg, kp_next;
    logic [CW-1:0] jnu_reg, jnu_next;
    logic [CW-1:0] span_reg, span_next;
    logic signed [KNOT_W-1:0] tj_reg, tj_next;
    logic signed [KNOT_W-1:0] t0_reg, t0_next;
    logic signed [KNOT_W-1:0] tb1_reg, tb1_next;
    logic signed [KNOT_W-1:0] e_reg, e_next;
    logic signed [KNOT_W-1:0] t2_reg, t2_next;
    logic signed [KNOT_W-1:0] tend_reg, tend_next;
    logic signed [KNOT_W-1:0] od_reg, od_next;
    logic signed [DIFF_W-1:0] d1_reg, d1_next;
    logic signed [DIFF_W-1:0] d2_reg, d2_next;
    logic zero_reg, zero_next;

    logic signed [KNOT_W-1:0] wv_reg [MAX_ORDER];
    logic signed [KNOT_W-1:0] nk_reg [NKD];
    logic                     wv_we;
    logic signed [SW-1:0]     wv_wr_idx, wv_rd_idx;
    logic signed [KNOT_W-1:0] wv_wr_data, wv_rd;
    logic                     nk_we;

    logic signed [SW-1:0] kk, nn, kil_c, kiu_c, kkh_c, lo_c, hi_c;
    logic [CW-1:0]        span_c, k_clamp;

    sc_req_t sc_req;
    sc_rsp_t sc_rsp;

    logic        emit;
    logic        out_valid_reg;
    logic [30:0] value_reg, value_next;
    logic [9:0]  sidx_reg, sidx_next;
    logic        last_reg, last_next;

    dbr_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sc_req),
        .rsp   (sc_rsp)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign accept        = start && !busy;
    assign load_in_range = (32'(knot_index) < KNOT_DEPTH);
    assign wr_addr       = KIW'(knot_index);

    assign orig_in = (orig_addr >= 0) && (orig_addr < $signed(SW'(KNOT_DEPTH)));
    assign ref_in  = (ref_addr >= 0) && (ref_addr < $signed(SW'(KNOT_DEPTH)));
    assign okd     = orig_oob_reg ? '0 : $signed(orig_q_reg);
    assign rkd     = ref_oob_reg ? '0 : $signed(ref_q_reg);

    assign kk      = ext(k_reg);
    assign nn      = $signed(SW'({1'b0, n_reg}));
    assign span_c  = kp_reg + k_reg - jnu_reg;
    assign kkh_c   = kiu_reg + kk - jm_reg - 1;
    assign k_clamp = (order_reg == '0) ? CW'(1) :
                     (32'(order_reg) > MAX_ORDER) ? CW'(MAX_ORDER) : CW'(order_reg);

    always_comb begin
        kil_c = jm_reg - ext(kp_reg);
        if (kil_c < 1) kil_c = 1;
        kiu_c = nn + ext(jnu_reg) - ext(kp_reg);
        if (kiu_c > jm_reg) kiu_c = jm_reg;
        lo_c = jm_reg - ext(jnu_reg);
        if (lo_c < 1) lo_c = 1;
        hi_c = (jm_reg < nn) ? jm_reg : nn;
    end

    // work value read, out-of-range entries read as zero
    assign wv_rd = ((wv_rd_idx >= 0) && (wv_rd_idx < kk)) ? wv_reg[wv_rd_idx[WIW-1:0]] : '0;

    always_comb begin : next_state
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (accept && op == OP_ROW) state_next = ST_WALK_RD;
            ST_WALK_RD:    state_next = (ki_reg < j_reg + kk) ? ST_WALK_CMP : ST_COLL_RD;
            ST_WALK_CMP:   state_next = (rkd == okd) ? ST_WALK_RD : ST_COLL_RD;
            ST_COLL_RD:    state_next = (kp_reg < k_reg) ? ST_COLL_CMP : ST_BUILD_INIT;
            ST_COLL_CMP:   state_next = ST_COLL_RD;
            ST_BUILD_INIT: state_next = ST_BUILD_T0;
            ST_BUILD_T0:   state_next = ST_KNOT_TOP;
            ST_KNOT_TOP: begin
                if (kp_reg >= jnu_reg) state_next = ST_EMIT_INIT;
                else if (ext(kp_reg) >= jm_reg) state_next = ST_TB_CAP;
                else state_next = ST_INNER_TOP;
            end
            ST_TB_CAP:     state_next = ST_TB_WAIT;
            ST_TB_WAIT:    if (sc_rsp.done) state_next = ST_INNER_TOP;
            ST_INNER_TOP: begin
                if (ki_reg <= kiu_reg) state_next = ST_INNER_RD2;
                else if (kiu_reg < jm_reg) state_next = ST_TAIL_RD2;
                else state_next = ST_KNOT_TOP;
            end
            ST_INNER_RD2:  state_next = ST_INNER_CAP;
            ST_INNER_CAP:  state_next = ST_T2_START;
            ST_T2_START:   state_next = ST_T2_WAIT;
            ST_T2_WAIT:    if (sc_rsp.done) state_next = ST_T1_START;
            ST_T1_START:   state_next = ST_T1_WAIT;
            ST_T1_WAIT:    if (sc_rsp.done) state_next = ST_INNER_TOP;
            ST_TAIL_RD2:   state_next = ST_TAIL_CAP;
            ST_TAIL_CAP:   state_next = ST_TAIL_START;
            ST_TAIL_START: state_next = ST_TAIL_WAIT;
            ST_TAIL_WAIT:  if (sc_rsp.done) state_next = ST_KNOT_TOP;
            ST_EMIT_INIT:  state_next = ST_EMIT;
            ST_EMIT: begin
                if ((ki_reg >= kiu_reg) || (kp_reg == CW'(MAX_ORDER - 1))) state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin : outputs
        k_next    = k_reg;
        n_next    = n_reg;
        j_next    = j_reg;
        jm_next   = jm_reg;
        ki_next   = ki_reg;
        kih_next  = kih_reg;
        kiu_next  = kiu_reg;
        kp_next   = kp_reg;
        jnu_next  = jnu_reg;
        span_next = span_reg;
        tj_next   = tj_reg;
        t0_next   = t0_reg;
        tb1_next  = tb1_reg;
        e_next    = e_reg;
        t2_next   = t2_reg;
        tend_next = tend_reg;
        od_next   = od_reg;
        d1_next   = d1_reg;
        d2_next   = d2_reg;
        zero_next = zero_reg | (sc_rsp.done & sc_rsp.zero);
        orig_addr  = '0;
        ref_addr   = '0;
        wv_we      = 1'b0;
        wv_wr_idx  = '0;
        wv_wr_data = '0;
        wv_rd_idx  = '0;
        nk_we      = 1'b0;
        sc_req     = '0;
        emit       = 1'b0;
        value_next = '0;
        sidx_next  = '0;
        last_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && op == OP_ROW) begin
                    k_next    = k_clamp;
                    n_next    = dim_reg;
                    j_next    = $signed(SW'({1'b0, row}));
                    jm_next   = $signed(SW'({1'b0, interval}));
                    ki_next   = $signed(SW'({1'b0, row})) + 1;
                    zero_next = 1'b0;
                end
            end
            ST_WALK_RD: begin
                ref_addr  = ki_reg;
                orig_addr = jm_reg;
                if (!(ki_reg < j_reg + kk)) begin
                    kih_next = jm_reg + 1;
                    jnu_next = '0;
                    kp_next  = CW'(1);
                end
            end
            ST_WALK_CMP: begin
                if (rkd == okd) begin
                    jm_next = jm_reg - 1;
                    ki_next = ki_reg + 1;
                end
                else begin
                    kih_next = jm_reg + 1;
                    jnu_next = '0;
                    kp_next  = CW'(1);
                end
            end
            ST_COLL_RD: begin
                ref_addr  = j_reg + ext(kp_reg);
                orig_addr = kih_reg;
            end
            ST_COLL_CMP: begin
                if (rkd == okd) kih_next = kih_reg + 1;
                else if (jnu_reg < CW'(MAX_ORDER - 1)) begin
                    nk_we    = 1'b1;
                    jnu_next = jnu_reg + 1'b1;
                end
                kp_next = kp_reg + 1'b1;
            end
            ST_BUILD_INIT: begin
                wv_we      = 1'b1;
                wv_wr_idx  = kk - 1;
                wv_wr_data = ONE_Q30;
                orig_addr  = '0;
            end
            ST_BUILD_T0: begin
                t0_next = okd;
                kp_next = '0;
            end
            ST_KNOT_TOP: begin
                if (kp_reg < jnu_reg) begin
                    tj_next   = nk_reg[kp_reg[NKW-1:0]];
                    span_next = span_c;
                    tb1_next  = '0;
                    ki_next   = kil_c;
                    kiu_next  = kiu_c;
                    orig_addr = ext(span_c);
                end
                else begin
                    ki_next  = lo_c;
                    kiu_next = hi_c;
                end
            end
            ST_TB_CAP: begin
                wv_rd_idx = kk - jm_reg - 1;
                sc_req.start = 1'b1;
                sc_req.a     = DIFF_W'(tj_reg) - DIFF_W'(t0_reg);
                sc_req.e     = wv_rd;
                sc_req.d     = DIV_W'(okd) - DIV_W'(t0_reg);
            end
            ST_TB_WAIT: if (sc_rsp.done) tb1_next = sc_rsp.q;
            ST_INNER_TOP: begin
                if (ki_reg <= kiu_reg) orig_addr = ki_reg;
                else if (kiu_reg < jm_reg) orig_addr = nn + kk - 1;
                else begin
                    wv_we      = 1'b1;
                    wv_wr_idx  = kkh_c;
                    wv_wr_data = tb1_reg;
                    kp_next    = kp_reg + 1'b1;
                end
            end
            ST_INNER_RD2: begin
                d1_next   = DIFF_W'(tj_reg) - DIFF_W'(okd);
                orig_addr = ki_reg + ext(span_reg);
            end
            ST_INNER_CAP: begin
                d2_next   = DIFF_W'(okd) - DIFF_W'(tj_reg);
                wv_rd_idx = ki_reg + kk - jm_reg - 1;
                e_next    = wv_rd;
            end
            ST_T2_START: begin
                sc_req.start = 1'b1;
                sc_req.a     = d2_reg;
                sc_req.e     = e_reg;
                sc_req.d     = DIV_W'(d1_reg) + DIV_W'(d2_reg);
            end
            ST_T2_WAIT: if (sc_rsp.done) t2_next = sc_rsp.q;
            ST_T1_START: begin
                sc_req.start = 1'b1;
                sc_req.a     = d1_reg;
                sc_req.e     = e_reg;
                sc_req.d     = DIV_W'(d1_reg) + DIV_W'(d2_reg);
            end
            ST_T1_WAIT: begin
                if (sc_rsp.done) begin
                    wv_we      = 1'b1;
                    wv_wr_idx  = ki_reg + kk - jm_reg - 2;
                    wv_wr_data = sat_add(t2_reg, tb1_reg);
                    tb1_next   = sc_rsp.q;
                    ki_next    = ki_reg + 1;
                end
            end
            ST_TAIL_RD2: begin
                tend_next = okd;
                orig_addr = kiu_reg + 1;
            end
            ST_TAIL_CAP: od_next = okd;
            ST_TAIL_START: begin
                wv_rd_idx    = kkh_c + 1;
                sc_req.start = 1'b1;
                sc_req.a     = DIFF_W'(tend_reg) - DIFF_W'(tj_reg);
                sc_req.e     = wv_rd;
                sc_req.d     = DIV_W'(tend_reg) - DIV_W'(od_reg);
            end
            ST_TAIL_WAIT: begin
                if (sc_rsp.done) begin
                    wv_we      = 1'b1;
                    wv_wr_idx  = kkh_c;
                    wv_wr_data = sat_add(tb1_reg, sc_rsp.q);
                    kp_next    = kp_reg + 1'b1;
                end
            end
            ST_EMIT_INIT: kp_next = '0;
            ST_EMIT: begin
                emit      = 1'b1;
                wv_rd_idx = ki_reg + kk - 1 - jm_reg;
                // empty spline range gives a single zero word
                if (ki_reg > kiu_reg) begin
                    last_next = 1'b1;
                end
                else begin
                    value_next = wv_rd[KNOT_W-1] ? '0 : wv_rd[30:0];
                    sidx_next  = ki_reg[9:0];
                    last_next  = (ki_reg == kiu_reg) || (kp_reg == CW'(MAX_ORDER - 1));
                    ki_next    = ki_reg + 1;
                    kp_next    = kp_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk) begin
        if (accept && op == OP_LOAD_ORIG && load_in_range) orig_mem[wr_addr] <= knot_value;
        if (accept && op == OP_LOAD_REF && load_in_range) ref_mem[wr_addr] <= knot_value;
        orig_q_reg   <= orig_mem[orig_addr[KIW-1:0]];
        ref_q_reg    <= ref_mem[ref_addr[KIW-1:0]];
        orig_oob_reg <= !orig_in;
        ref_oob_reg  <= !ref_in;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            order_reg     <= ORDER_RESET;
            dim_reg       <= DIM_RESET;
            out_valid_reg <= 1'b0;
            zero_reg      <= 1'b0;
            for (int i = 0; i < MAX_ORDER; i++) begin
                wv_reg[i] <= '0;
            end
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= emit;
            zero_reg      <= zero_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ORDER: order_reg <= cfg_data[3:0];
                    CFG_DIM:   dim_reg   <= cfg_data;
                    default:   ;
                endcase
            end
            if (wv_we && (wv_wr_idx >= 0) && (wv_wr_idx < kk)) begin
                wv_reg[wv_wr_idx[WIW-1:0]] <= wv_wr_data;
            end
        end
    end

    always_ff @(posedge clk) begin
        k_reg    <= k_next;
        n_reg    <= n_next;
        j_reg    <= j_next;
        jm_reg   <= jm_next;
        ki_reg   <= ki_next;
        kih_reg  <= kih_next;
        kiu_reg  <= kiu_next;
        kp_reg   <= kp_next;
        jnu_reg  <= jnu_next;
        span_reg <= span_next;
        tj_reg   <= tj_next;
        t0_reg   <= t0_next;
        tb1_reg  <= tb1_next;
        e_reg    <= e_next;
        t2_reg   <= t2_next;
        tend_reg <= tend_next;
        od_reg   <= od_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        if (nk_we) nk_reg[jnu_reg[NKW-1:0]] <= rkd;
        if (emit) begin
            value_reg <= value_next;
            sidx_reg  <= sidx_next;
            last_reg  <= last_next;
            last_position   <= jm_reg[9:0];
            count_minus_one <= jnu_reg[2:0];
            status          <= zero_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = value_reg;
    assign spline_index = sidx_reg;
    assign last         = last_reg;

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result word without an emit cycle");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last == !busy))
        else $error("last flag out of step with end of row");

    a_scale_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        sc_req.start |=> !sc_req.start)
        else $error("scaler started twice in a row");

    a_row_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_ROW) |=> busy)
        else $error("row word did not start the sequencer");

endmodule

@@ bench/discrete_bspline_row_test.sv @@
// ----------------------------------------------------------------------------
// discrete_bspline_row_test
// self-checking bench for the discrete b-spline row block
// ----------------------------------------------------------------------------
// Fills both knot stores with a uniform vector and its midpoint refinement,
// then sends directed and random load and row words under several order and
// dimension settings and sender idling rates. A scoreboard class predicts the
// refinement matrix row for every row word and checks each strobed result.
// ----------------------------------------------------------------------------
module discrete_bspline_row_test;
    import dbr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ORDER_CAP = 8;
    localparam int STORE_DEPTH = 1024;

    typedef struct {
        logic [30:0] value;
        logic [9:0]  spline_index;
        logic [9:0]  last_position;
        logic [2:0]  count_minus_one;
        logic        status;
        logic        last;
    } row_value_t;

    class row_scoreboard;
        int tau [STORE_DEPTH];
        int tref [STORE_DEPTH];
        int work [ORDER_CAP];
        int fresh [ORDER_CAP-1];
        logic [3:0] order_reg;
        logic [9:0] dim_reg;
        bit zero_div;
        int fails;
        row_value_t pending_values[$];

        function new();
            foreach (work[i]) work[i] = 0;
            foreach (fresh[i]) fresh[i] = 0;
            order_reg = ORDER_RESET;
            dim_reg = DIM_RESET;
            fails = 0;
        endfunction

        function void set_reg(logic idx, logic [9:0] data);
            if (idx == CFG_ORDER) order_reg = data[3:0];
            else dim_reg = data;
        endfunction

        function longint tau_at(longint i);
            if (i < 0 || i >= STORE_DEPTH) return 0;
            return tau[i];
        endfunction

        function longint ref_at(longint i);
            if (i < 0 || i >= STORE_DEPTH) return 0;
            return tref[i];
        endfunction

        function int wget(longint i, longint k);
            if (i < 0 || i >= k || i >= ORDER_CAP) return 0;
            return work[i];
        endfunction

        function void wset(longint i, longint k, int v);
            if (i < 0 || i >= k || i >= ORDER_CAP) return;
            work[i] = v;
        endfunction

        function int sat32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return int'(v);
        endfunction

        // a*e/d rounded half away from zero, saturated
        function int scale(longint a, int e, longint d);
            longint prod;
            bit neg;
            longint unsigned mn, md, q;
            if (d == 0) begin
                zero_div = 1;
                return 0;
            end
            prod = a * longint'(e);
            neg = (prod < 0) != (d < 0);
            mn = prod < 0 ? longint'(-prod) : prod;
            md = d < 0 ? longint'(-d) : d;
            q = (mn + md / 2) / md;
            if (q > 64'd2147483647) q = neg ? 64'd2147483648 : 64'd2147483647;
            return neg ? int'(-longint'(q)) : int'(q);
        endfunction

        function void note_word(logic [1:0] op, logic [9:0] idx, logic signed [31:0] kv,
                                logic [9:0] rw, logic [9:0] iv);
            longint k, k1, n, j, jm, ki, kp, kih, jnu, lo, hi, cnt;
            longint tj, t0, span, kil, kiu, kkh, d1, d2, tend, t;
            int tb1, e, t1, t2, add;
            row_value_t res;
            if (op == OP_LOAD_ORIG) begin
                tau[idx] = kv;
                return;
            end
            if (op == OP_LOAD_REF) begin
                tref[idx] = kv;
                return;
            end
            if (op != OP_ROW) return;
            k = order_reg;
            if (k < 1) k = 1;
            if (k > ORDER_CAP) k = ORDER_CAP;
            k1 = k - 1;
            n = dim_reg;
            j = rw;
            jm = iv;
            zero_div = 0;
            // walk down past knots shared by both vectors
            for (ki = j + 1; ki < j + k && ref_at(ki) == tau_at(jm); ki++) jm--;
            kih = jm + 1;
            jnu = 0;
            for (kp = 1; kp <= k1; kp++) begin
                t = ref_at(j + kp);
                if (t == tau_at(kih)) kih++;
                else if (jnu < ORDER_CAP - 1) begin
                    fresh[jnu] = int'(t);
                    jnu++;
                end
            end
            wset(k1, k, ONE_Q30);
            for (kp = 0; kp < jnu; kp++) begin
                tj = fresh[kp];
                t0 = tau_at(0);
                span = kp + k - jnu;
                tb1 = 0;
                if (kp >= jm) tb1 = scale(tj - t0, wget(k - jm - 1, k), tau_at(span) - t0);
                kil = jm - kp;
                if (kil < 1) kil = 1;
                kiu = n + jnu - kp;
                if (kiu > jm) kiu = jm;
                for (ki = kil; ki <= kiu; ki++) begin
                    d1 = tj - tau_at(ki);
                    d2 = tau_at(ki + span) - tj;
                    e = wget(ki + k - jm - 1, k);
                    t2 = scale(d2, e, d1 + d2);
                    t1 = scale(d1, e, d1 + d2);
                    wset(ki + k - jm - 2, k, sat32(longint'(t2) + tb1));
                    tb1 = t1;
                end
                kkh = kiu + k - jm - 1;
                if (kiu < jm) begin
                    tend = tau_at(n + k - 1);
                    add = scale(tend - tj, wget(kkh + 1, k), tend - tau_at(kiu + 1));
                    wset(kkh, k, sat32(longint'(tb1) + add));
                end else begin
                    wset(kkh, k, tb1);
                end
            end
            lo = jm - jnu;
            if (lo < 1) lo = 1;
            hi = jm < n ? jm : n;
            cnt = hi >= lo ? hi - lo + 1 : 0;
            if (cnt > ORDER_CAP) cnt = ORDER_CAP;
            res.last_position = jm[9:0];
            res.count_minus_one = jnu[2:0];
            res.status = zero_div;
            if (cnt == 0) begin
                res.value = '0;
                res.spline_index = '0;
                res.last = 1;
                pending_values.push_back(res);
                return;
            end
            for (longint r = 0; r < cnt; r++) begin
                e = wget(lo + r + k - 1 - jm, k);
                res.value = e < 0 ? 31'd0 : e[30:0];
                res.spline_index = 10'(lo + r);
                res.last = (r == cnt - 1);
                pending_values.push_back(res);
            end
        endfunction

        function void check_value(row_value_t got);
            row_value_t want;
            if (pending_values.size() == 0) begin
                $error("result with nothing expected: spline_index %0d", got.spline_index);
                fails++;
                return;
            end
            want = pending_values.pop_front();
            if (got.value !== want.value) begin
                $error("value: expected %h, got %h", want.value, got.value);
                fails++;
            end
            if (got.spline_index !== want.spline_index) begin
                $error("spline_index: expected %0d, got %0d", want.spline_index,
                       got.spline_index);
                fails++;
            end
            if (got.last_position !== want.last_position) begin
                $error("last_position: expected %0d, got %0d", want.last_position,
                       got.last_position);
                fails++;
            end
            if (got.count_minus_one !== want.count_minus_one) begin
                $error("count_minus_one: expected %0d, got %0d", want.count_minus_one,
                       got.count_minus_one);
                fails++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [9:0]  knot_index;
    logic signed [31:0] knot_value;
    logic [9:0]  row;
    logic [9:0]  interval;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [9:0]  cfg_data;
    logic        result_valid;
    logic [30:0] value;
    logic [9:0]  spline_index;
    logic [9:0]  last_position;
    logic [2:0]  count_minus_one;
    logic        status;
    logic        last;

    row_scoreboard sb;
    int idle_pct;

    discrete_bspline_row uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .knot_index(knot_index), .knot_value(knot_value), .row(row),
        .interval(interval), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
        .value(value), .spline_index(spline_index), .last_position(last_position),
        .count_minus_one(count_minus_one), .status(status), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        row_value_t got;
        if (rst_n && result_valid) begin
            got.value = value;
            got.spline_index = spline_index;
            got.last_position = last_position;
            got.count_minus_one = count_minus_one;
            got.status = status;
            got.last = last;
            sb.check_value(got);
        end
    end

    // start stays high across back-to-back words
    task automatic send_word(logic [1:0] o, logic [9:0] idx, logic [31:0] kv,
                             logic [9:0] rw, logic [9:0] iv);
        start <= 1'b1;
        op <= o;
        knot_index <= idx;
        knot_value <= kv;
        row <= rw;
        interval <= iv;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_word(o, idx, kv, rw, iv);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_values.size() != 0 || busy) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic random_word();
        int pick;
        int j;
        pick = $urandom_range(99);
        j = $urandom_range(1, 1023);
        if (pick < 55) begin
            send_word(OP_ROW, $urandom, $urandom, j, j / 2);
        end else if (pick < 68) begin
            send_word(OP_ROW, $urandom, $urandom, j, $urandom_range(0, 1023));
        end else if (pick < 78) begin
            // duplicate a neighbor to build knot multiplicity
            j = $urandom_range(1, 1022);
            send_word(OP_LOAD_ORIG, j, sb.tau[j - 1], $urandom, $urandom);
        end else if (pick < 86) begin
            j = $urandom_range(0, 1021);
            send_word(OP_LOAD_REF, j, sb.tau[(j + 1) / 2], $urandom, $urandom);
        end else if (pick < 95) begin
            send_word($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
        end else begin
            send_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        #(8 * 4_000_000);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int orders [6] = '{4, 8, 1, 0, 15, 3};
        int dims [6] = '{16, 1016, 1, 1023, 500, 0};
        int idles [6] = '{0, 48, 48, 36, 0, 36};
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_LOAD_ORIG;
        knot_index = '0;
        knot_value = '0;
        row = '0;
        interval = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ORDER;
        cfg_data = '0;
        idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // uniform original vector and its midpoint refinement
        for (int i = 0; i < STORE_DEPTH; i++) send_word(OP_LOAD_ORIG, i, i << 16, 0, 0);
        for (int i = 0; i < STORE_DEPTH; i++)
            send_word(OP_LOAD_REF, i, ((i / 2) << 16) + ((i % 2) << 15), 0, 0);

        // directed: extremes, repeated knots, unused op
        send_word(OP_ROW, 0, 0, 1, 0);
        send_word(OP_ROW, 0, 0, 20, 10);
        send_word(OP_ROW, 0, 0, 1023, 1023);
        send_word(OP_ROW, 0, 0, 1023, 0);
        send_word(OP_LOAD_ORIG, 601, 600 << 16, 0, 0);
        send_word(OP_LOAD_ORIG, 602, 600 << 16, 0, 0);
        send_word(OP_ROW, 0, 0, 1200, 600);
        send_word(OP_ROW, 0, 0, 1198, 599);
        send_word(OP_LOAD_ORIG, 900, 32'sh7FFF_FFFF, 0, 0);
        send_word(OP_LOAD_ORIG, 901, 32'sh8000_0000, 0, 0);
        send_word(OP_LOAD_REF, 1801 - 1024, 32'sh8000_0000, 0, 0);
        send_word(OP_ROW, 0, 0, 776, 900);
        send_word(OP_ROW, 0, 0, 1023, 901);
        send_word(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
        send_word(OP_ROW, 0, 0, 31, 15);
        send_word(OP_ROW, 0, 0, 2, 1);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_ORDER, orders[p]);
            write_reg(CFG_DIM, dims[p]);
            idle_pct = idles[p];
            @(posedge clk);
            repeat (28) random_word();
            drain();
        end

        if (sb.fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/dbr_pkg.sv
sv/dbr_scale.sv
sv/discrete_bspline_row.sv
bench/discrete_bspline_row_test.sv
